[rtl/rbp_pkg.sv]
// Shared constants, types and helper functions of the raster block pooling core.
// Used by rbp_recip and raster_block_pooling_core; depends on nothing else.

package rbp_pkg;

	// Sizing of the core
	localparam int MAX_WIDTH = 4096;
	localparam int MAX_BLOCK = 64;

	// Field and register widths
	localparam int PIX_W      = 16;
	localparam int OUT_W      = 32;
	localparam int IW_W       = 13;
	localparam int IH_W       = 16;
	localparam int BS_W       = 7;
	localparam int MODE_W     = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Derived widths
	localparam int COL_W   = $clog2(MAX_WIDTH);
	localparam int EW_W    = $clog2(MAX_WIDTH + 1);
	localparam int ROW_W   = IH_W;
	localparam int CIB_W   = $clog2(MAX_BLOCK);
	localparam int B_W     = $clog2(MAX_BLOCK + 1);
	localparam int AREA_W  = 2 * $clog2(MAX_BLOCK) + 1;
	localparam int ACC_W   = PIX_W + 2 * $clog2(MAX_BLOCK);
	localparam int RES_W   = ACC_W + 1;
	localparam int L_MAX   = 2 * $clog2(MAX_BLOCK);
	localparam int L_W     = $clog2(L_MAX + 1);
	localparam int M_W     = ACC_W + 2;
	localparam int PROD_W  = ACC_W + M_W;
	localparam int NUM_W   = ACC_W + L_MAX + 1;
	localparam int CNT_W   = $clog2(NUM_W);

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd3;

	// Statistic codes
	localparam logic [MODE_W-1:0] MODE_MEAN = 2'd0;
	localparam logic [MODE_W-1:0] MODE_SUM  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_MIN  = 2'd2;
	localparam logic [MODE_W-1:0] MODE_MAX  = 2'd3;

	// Register values after reset
	localparam logic [IW_W-1:0]   RST_WIDTH  = 13'd640;
	localparam logic [IH_W-1:0]   RST_HEIGHT = 16'd480;
	localparam logic [BS_W-1:0]   RST_BLOCK  = 7'd2;
	localparam logic [MODE_W-1:0] RST_MODE   = MODE_MEAN;

	// Reciprocal of the block area as seen by the mean path
	typedef struct packed {
		logic             busy;
		logic [M_W-1:0]   mult;
		logic [L_W-1:0]   shift;
	} rbp_recip_t;

	// Smallest l with 2**l >= area
	function automatic logic [L_W-1:0] ceil_log2(input logic [AREA_W-1:0] area);
		logic [L_W-1:0] l;
		l = L_W'(L_MAX);
		for (int i = L_MAX; i >= 0; i--) begin
			if ((32'd1 << i) >= 32'(area)) begin
				l = L_W'(i);
			end
		end
		return l;
	endfunction

	// Clamp a result to the signed 32-bit output range
	function automatic logic [OUT_W-1:0] sat_out(input logic signed [RES_W-1:0] v);
		logic [OUT_W-1:0] r;
		if (64'(longint'(v)) > 64'sd2147483647) begin
			r = 32'h7FFF_FFFF;
		end else if (longint'(v) < -64'sd2147483648) begin
			r = 32'h8000_0000;
		end else begin
			r = 32'(v);
		end
		return r;
	endfunction

endpackage

[rtl/rbp_ram.sv]
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies; the accumulator store of the pooling core is one instance.

module rbp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port, and read port returning the old contents on a collision.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/rbp_recip.sv]
// Reciprocal unit: works out m = ceil(2**(ACC_W+l) / area) one quotient bit per cycle.
// Depends on rbp_pkg; used by raster_block_pooling_core for the mean.

module rbp_recip
	import rbp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [AREA_W-1:0] area,
	output rbp_recip_t        recip
);

	logic              going_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [AREA_W-1:0] div_q;
	logic [AREA_W-1:0] rem_q;
	logic [NUM_W-1:0]  quo_q;
	logic [L_W-1:0]    lw_q;
	logic [M_W-1:0]    mult_q;
	logic [L_W-1:0]    shift_q;

	logic              num_bit;
	logic [AREA_W:0]   rem_sh;
	logic              fits;
	logic [AREA_W-1:0] rem_nx;
	logic [NUM_W-1:0]  quo_nx;

	// One restoring division step; the dividend holds a single one at bit ACC_W+l.
	always_comb begin
		num_bit = (32'(cnt_q) == ACC_W + 32'(lw_q));
		rem_sh  = {rem_q, num_bit};
		fits    = (rem_sh >= {1'b0, div_q});
		rem_nx  = fits ? AREA_W'(rem_sh - {1'b0, div_q}) : rem_q << 1 | AREA_W'(num_bit);
		quo_nx  = {quo_q[NUM_W-2:0], fits};
	end

	// Sequencer of the division.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			going_q <= 1'b0;
			cnt_q   <= '0;
		end else if (start) begin
			going_q <= 1'b1;
			cnt_q   <= CNT_W'(NUM_W - 1);
		end else if (going_q) begin
			if (cnt_q == '0) begin
				going_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Datapath of the division and the result registers.
	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= area;
			lw_q  <= ceil_log2(area);
			rem_q <= '0;
			quo_q <= '0;
		end else if (going_q) begin
			rem_q <= rem_nx;
			quo_q <= quo_nx;
			if (cnt_q == '0) begin
				mult_q  <= M_W'(quo_nx) + M_W'(rem_nx != '0);
				shift_q <= lw_q;
			end
		end
	end

	assign recip.busy  = going_q;
	assign recip.mult  = mult_q;
	assign recip.shift = shift_q;

endmodule

[rtl/raster_block_pooling_core.sv]
// Top level of the raster block pooling core: counters, accumulator pipeline, output register.
// Depends on rbp_pkg, rbp_ram and rbp_recip.

// Pixels of one band enter in raster order, one per cycle while s_tready is high, and
// each completed square block leaves as one result (mean, sum, minimum or maximum) in
// raster order of blocks, with tlast on the final block of the image. Partial results
// of the block row in progress sit in a 4096 x 28 single-port-read RAM, one entry per
// block column; each pixel reads its entry on acceptance and writes it back from
// stage 1, a forward path covering back-to-back pixels of the same block column.
// A result passes stages 1 to 4 and then the output register after its last pixel
// is taken. After reset and after every write of block_size, no pixel is taken while
// a bit-serial unit forms the reciprocal of the block area used by the mean. While a
// result waits at the output and the next one has reached the last stage, the whole
// pipeline holds. Any register write starts a new image; blocks at the right and bottom
// edges are cut, but the mean divides by the full block area.

module raster_block_pooling_core
	import rbp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// Pixel stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [PIX_W-1:0]      s_tdata,   // [15:0] pixel_value
	// Result stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_W-1:0]      m_tdata,   // [31:0] group_value
	output logic                  m_tlast,
	// Configuration
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// Configuration registers
	logic [IW_W-1:0]   image_width_q;
	logic [IH_W-1:0]   image_height_q;
	logic [BS_W-1:0]   block_size_q;
	logic [MODE_W-1:0] mode_q;
	logic              recalc_q;

	// Position counters
	logic [COL_W-1:0]  pixel_column_q;
	logic [ROW_W-1:0]  pixel_row_q;
	logic [CIB_W-1:0]  column_in_block_q;
	logic [CIB_W-1:0]  row_in_block_q;
	logic [COL_W-1:0]  block_column_q;

	logic [EW_W-1:0]   eff_w;
	logic [IH_W-1:0]   eff_h;
	logic [B_W-1:0]    eff_b;
	logic [2*B_W-1:0]  area_sq;
	logic [AREA_W-1:0] area;

	logic              col_last, cib_last, row_last, rib_last;
	logic              accept, adv, busy;
	rbp_recip_t        recip;

	// Stage 1: read-modify-write of the accumulator
	logic                    valid_s1, first_s1, res_s1, eoi_s1, hit_s1;
	logic signed [PIX_W-1:0] pix_s1;
	logic [COL_W-1:0]        addr_s1;
	logic signed [ACC_W-1:0] fwd_s1;
	logic [ACC_W-1:0]        ram_rdata;
	logic signed [ACC_W-1:0] old_acc, pix_ext, acc_new;

	// Stages 2 to 4: result path
	logic                    valid_s2, eoi_s2;
	logic signed [ACC_W-1:0] acc_s2;
	logic                    valid_s3, eoi_s3, neg_s3;
	logic signed [ACC_W-1:0] acc_s3;
	logic [ACC_W-1:0]        num_s3;
	logic                    valid_s4, eoi_s4, neg_s4;
	logic signed [ACC_W-1:0] acc_s4;
	logic [PROD_W-1:0]       prod_s4;
	logic [ACC_W-1:0]        mag_s2, num_s2;
	logic [PROD_W-1:0]       quo_full;
	logic signed [RES_W-1:0] res_val;

	// Output register
	logic                    out_valid_q, eoi_q;
	logic [OUT_W-1:0]        group_value_q;

	// Effective register values.
	always_comb begin
		if (image_width_q == '0) begin
			eff_w = EW_W'(1);
		end else if (32'(image_width_q) > MAX_WIDTH) begin
			eff_w = EW_W'(MAX_WIDTH);
		end else begin
			eff_w = EW_W'(image_width_q);
		end
		eff_h = (image_height_q == '0) ? IH_W'(1) : image_height_q;
		if (block_size_q == '0) begin
			eff_b = B_W'(1);
		end else if (32'(block_size_q) > MAX_BLOCK) begin
			eff_b = B_W'(MAX_BLOCK);
		end else begin
			eff_b = B_W'(block_size_q);
		end
		area_sq = eff_b * eff_b;
		area    = AREA_W'(area_sq);
	end

	// Edge tests of the current pixel position.
	assign col_last = (32'(pixel_column_q) + 1 >= 32'(eff_w));
	assign cib_last = (32'(column_in_block_q) + 1 >= 32'(eff_b));
	assign row_last = (32'(pixel_row_q) + 1 >= 32'(eff_h));
	assign rib_last = (32'(row_in_block_q) + 1 >= 32'(eff_b));

	// Handshake: the pipeline holds only when a result would overrun the output register.
	assign busy     = recalc_q || recip.busy;
	assign adv      = !(valid_s4 && out_valid_q && !m_tready);
	assign s_tready = adv && !busy;
	assign accept   = s_tvalid && s_tready;

	// Configuration registers; a block size write asks for a new reciprocal.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= RST_WIDTH;
			image_height_q <= RST_HEIGHT;
			block_size_q   <= RST_BLOCK;
			mode_q         <= RST_MODE;
			recalc_q       <= 1'b1;
		end else begin
			recalc_q <= cfg_we && (cfg_index == REG_BLOCK);
			if (cfg_we) begin
				case (cfg_index)
					REG_WIDTH:  image_width_q  <= cfg_data[IW_W-1:0];
					REG_HEIGHT: image_height_q <= cfg_data[IH_W-1:0];
					REG_BLOCK:  block_size_q   <= cfg_data[BS_W-1:0];
					REG_MODE:   mode_q         <= cfg_data[MODE_W-1:0];
					default:    mode_q         <= mode_q;
				endcase
			end
		end
	end

	// Position counters; every register write starts a new image.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_column_q    <= '0;
			pixel_row_q       <= '0;
			column_in_block_q <= '0;
			row_in_block_q    <= '0;
			block_column_q    <= '0;
		end else if (cfg_we) begin
			pixel_column_q    <= '0;
			pixel_row_q       <= '0;
			column_in_block_q <= '0;
			row_in_block_q    <= '0;
			block_column_q    <= '0;
		end else if (accept) begin
			if (col_last) begin
				pixel_column_q    <= '0;
				column_in_block_q <= '0;
				block_column_q    <= '0;
				if (row_last) begin
					pixel_row_q    <= '0;
					row_in_block_q <= '0;
				end else begin
					pixel_row_q    <= pixel_row_q + 1'b1;
					row_in_block_q <= rib_last ? '0 : row_in_block_q + 1'b1;
				end
			end else begin
				pixel_column_q <= pixel_column_q + 1'b1;
				if (cib_last) begin
					column_in_block_q <= '0;
					block_column_q    <= block_column_q + 1'b1;
				end else begin
					column_in_block_q <= column_in_block_q + 1'b1;
				end
			end
		end
	end

	// Reciprocal of the block area for the mean.
	rbp_recip u_recip (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (recalc_q),
		.area   (area),
		.recip  (recip)
	);

	// Accumulator store, one entry per block column.
	rbp_ram #(
		.WIDTH (ACC_W),
		.DEPTH (MAX_WIDTH)
	) u_acc_ram (
		.clk   (clk),
		.we    (valid_s1 && adv),
		.waddr (addr_s1),
		.wdata (acc_new),
		.re    (accept),
		.raddr (block_column_q),
		.rdata (ram_rdata)
	);

	// Stage 1 control; a hit means the entry was written at the edge it was read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			hit_s1   <= 1'b0;
		end else if (adv) begin
			valid_s1 <= accept;
			hit_s1   <= valid_s1 && (addr_s1 == block_column_q);
		end
	end

	// Stage 1 payload and the forward copy of the value being written back.
	always_ff @(posedge clk) begin
		if (adv) begin
			fwd_s1 <= acc_new;
			if (accept) begin
				pix_s1   <= $signed(s_tdata);
				addr_s1  <= block_column_q;
				first_s1 <= (column_in_block_q == '0) && (row_in_block_q == '0);
				res_s1   <= (cib_last || col_last) && (rib_last || row_last);
				eoi_s1   <= col_last && row_last;
			end
		end
	end

	// Update of the running statistic.
	always_comb begin
		old_acc = hit_s1 ? fwd_s1 : $signed(ram_rdata);
		pix_ext = ACC_W'(pix_s1);
		if (first_s1) begin
			acc_new = pix_ext;
		end else begin
			case (mode_q)
				MODE_MEAN, MODE_SUM: acc_new = old_acc + pix_ext;
				MODE_MIN:            acc_new = (pix_ext < old_acc) ? pix_ext : old_acc;
				MODE_MAX:            acc_new = (pix_ext > old_acc) ? pix_ext : old_acc;
				default:             acc_new = old_acc;
			endcase
		end
	end

	// Magnitude plus half the area, for rounding with ties away from zero.
	always_comb begin
		mag_s2 = acc_s2[ACC_W-1] ? ACC_W'(-acc_s2) : ACC_W'(acc_s2);
		num_s2 = mag_s2 + ACC_W'(area >> 1);
	end

	// Quotient by the reciprocal, sign restored, and the statistic selected.
	always_comb begin
		quo_full = prod_s4 >> (ACC_W + int'(recip.shift));
		if (mode_q == MODE_MEAN) begin
			res_val = neg_s4 ? -$signed({1'b0, quo_full[ACC_W-1:0]})
			                 :  $signed({1'b0, quo_full[ACC_W-1:0]});
		end else begin
			res_val = RES_W'(acc_s4);
		end
	end

	// Result path valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1 && res_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// Result path payload: capture, rounding numerator, product.
	always_ff @(posedge clk) begin
		if (adv) begin
			acc_s2  <= acc_new;
			eoi_s2  <= eoi_s1;
			acc_s3  <= acc_s2;
			eoi_s3  <= eoi_s2;
			neg_s3  <= acc_s2[ACC_W-1];
			num_s3  <= num_s2;
			acc_s4  <= acc_s3;
			eoi_s4  <= eoi_s3;
			neg_s4  <= neg_s3;
			prod_s4 <= PROD_W'(num_s3) * PROD_W'(recip.mult);
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && valid_s4) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s4) begin
			group_value_q <= sat_out(res_val);
			eoi_q         <= eoi_s4;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = group_value_q;
	assign m_tlast  = eoi_q;

`ifndef SYNTHESIS
	// No pixel is taken while the reciprocal is being formed.
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |-> !recip.busy && !recalc_q)
		else $error("pixel accepted while the reciprocal unit is busy");

	// A block size write closes the input on the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_we && cfg_index == REG_BLOCK) |=> !s_tready)
		else $error("input open right after a block size write");

	// A waiting result is never overrun by the last stage.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s4 && m_tvalid && !m_tready) |-> !adv && !s_tready)
		else $error("pipeline advanced into a stalled output register");

	// A write-back to the entry being read sets the forward hit.
	assert property (@(posedge clk) disable iff (!arst_n)
		(adv && valid_s1 && accept && (addr_s1 == block_column_q)) |=> hit_s1)
		else $error("write-back to the entry being read left the forward hit clear");
`endif

endmodule
